/* rtl/ptet_pkg.sv */
// ----------------------------------------------------------------------------
// ptet_pkg
// shared widths, codes, reset values and interface types of the touch tracker
// ----------------------------------------------------------------------------
package ptet_pkg;

    localparam int FINGER_COUNT_DEF = 5;
    localparam int FINGER_W         = 3;
    localparam int POS_W            = 24;
    localparam int UV_W             = 16;
    localparam int PRES_W           = 16;
    localparam int KIND_W           = 2;
    localparam int EXT_W            = 23;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 23;
    localparam int IN_DATA_W        = 80;
    localparam int OUT_DATA_W       = 56;

    // shared divider
    localparam int DIVIDEND_W = 39;
    localparam int DIVISOR_W  = 23;
    localparam int QUOT_W     = 18;
    localparam int DIV_CNT_W  = 5;
    localparam int DS_W       = DIVISOR_W + QUOT_W - 1;

    localparam logic [DIV_CNT_W-1:0] TOP_UV   = 5'd17;
    localparam logic [DIV_CNT_W-1:0] TOP_PRES = 5'd15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_AXIS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_U    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_V    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_DIST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED     = 3'd5;

    // register reset values
    localparam logic [1:0]       RST_NORMAL_AXIS = 2'd2;
    localparam logic [EXT_W-1:0] RST_EXTENT      = 23'd25600;
    localparam logic [EXT_W-1:0] RST_TOUCH_DIST  = 23'd512;
    localparam logic [4:0]       RST_ALLOWED     = 5'd31;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    // event kinds
    localparam logic [KIND_W-1:0] EV_BEGAN = 2'd0;
    localparam logic [KIND_W-1:0] EV_MOVED = 2'd1;
    localparam logic [KIND_W-1:0] EV_ENDED = 2'd2;

    // Q2.14 constants
    localparam logic signed [UV_W-1:0] MINUS_ONE_Q14 = -16'sd16384;
    localparam logic signed [UV_W-1:0] ONE_Q14       = 16'sd16384;
    localparam logic signed [19:0]     HALF_Q14      = 20'sd8192;
    localparam logic signed [19:0]     UV_MAX        = 20'sd32767;
    localparam logic signed [19:0]     UV_MIN        = -20'sd32768;
    localparam logic signed [16:0]     MOVE_TOL      = 17'sd16;

    typedef struct packed {
        logic                  start;
        logic [DIV_CNT_W-1:0]  top;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic                   touching;
        logic signed [UV_W-1:0] last_u;
        logic signed [UV_W-1:0] last_v;
    } t_fs_entry;

    typedef struct packed {
        logic      we;
        t_fs_entry entry;
    } t_fs_wr;

endpackage

/* rtl/ptet_div.sv */
// ----------------------------------------------------------------------------
// ptet_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ptet_div
    import ptet_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIVIDEND_W-1:0] r_rem;
    logic [DS_W-1:0]       r_ds;
    logic [QUOT_W-1:0]     r_q;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DS_W:0] diff;
    logic          ge;

    // top step flags a quotient too large for the sequence that follows
    assign diff = {{(DS_W + 1 - DIVIDEND_W){1'b0}}, r_rem} - {1'b0, r_ds};
    assign ge   = !diff[DS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.top;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_ds  <= DS_W'({{(DS_W - DIVISOR_W){1'b0}}, i_req.divisor} << i_req.top);
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= diff[DIVIDEND_W-1:0];
            end
            r_q  <= {r_q[QUOT_W-2:0], ge};
            r_ds <= r_ds >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

/* rtl/ptet_fstate.sv */
// ----------------------------------------------------------------------------
// ptet_fstate
// per-finger touching flag and last uv
// ----------------------------------------------------------------------------
module ptet_fstate
    import ptet_pkg::*;
#(
    parameter int FINGER_COUNT = FINGER_COUNT_DEF,
    parameter int IDX_W        = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  t_fs_wr           i_wr,
    output t_fs_entry        o_rd
);

    t_fs_entry r_fs [FINGER_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FINGER_COUNT; i++) begin
                r_fs[i].touching <= 1'b0;
                r_fs[i].last_u   <= MINUS_ONE_Q14;
                r_fs[i].last_v   <= MINUS_ONE_Q14;
            end
        end else if (i_wr.we) begin
            r_fs[i_idx] <= i_wr.entry;
        end
    end

    assign o_rd = r_fs[i_idx];

endmodule

/* rtl/proximity_touch_event_tracker_unit.sv */
// ----------------------------------------------------------------------------
// proximity_touch_event_tracker_unit
// fingertip samples in, touch began / moved / ended events out
// ----------------------------------------------------------------------------
// sequence: input transfer, check, divide for u, divide for v, touch test,
//   divide for pressure on a touching sample only, then emit to the output
//   register; an ignored sample gives no event
// intake: no new transfer until the sequencer is back in idle, which the
//   single shared divider and a full output slot at emit can hold off
// reset: synchronous active low, registers to their reset values, all
//   fingers released with last uv at minus one, no clearing pass
// ----------------------------------------------------------------------------
module proximity_touch_event_tracker_unit
    import ptet_pkg::*;
#(
    parameter int FINGER_COUNT = FINGER_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // sample stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // finger[2:0], pos_x[26:3], pos_y[50:27], pos_z[74:51], zero fill above
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // event stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // event_finger[2:0], coord_u[18:3], coord_v[34:19], pressure[50:35], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // event_kind[1:0]
    output logic [KIND_W-1:0]     m_axis_tuser
);

    localparam int IDX_W = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;
    localparam int XW    = (IDX_W > FINGER_W) ? IDX_W : FINGER_W;

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIVU  = 3'd2;
    localparam logic [2:0] S_DIVV  = 3'd3;
    localparam logic [2:0] S_TOUCH = 3'd4;
    localparam logic [2:0] S_PRES  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    // configuration registers
    logic             r_enabled;
    logic [1:0]       r_normal_axis;
    logic [EXT_W-1:0] r_extent_u;
    logic [EXT_W-1:0] r_extent_v;
    logic [EXT_W-1:0] r_touch_dist;
    logic [4:0]       r_allowed;

    // captured sample
    logic [FINGER_W-1:0]     r_finger;
    logic signed [POS_W-1:0] r_pos_x;
    logic signed [POS_W-1:0] r_pos_y;
    logic signed [POS_W-1:0] r_pos_z;

    // working results
    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic signed [UV_W-1:0]  r_u;
    logic signed [UV_W-1:0]  r_v;
    logic                    r_touch;
    logic [PRES_W-1:0]       r_pres;

    // output register
    logic                    r_m_valid;
    logic [KIND_W-1:0]       r_m_kind;
    logic [FINGER_W-1:0]     r_m_finger;
    logic signed [UV_W-1:0]  r_m_u;
    logic signed [UV_W-1:0]  r_m_v;
    logic [PRES_W-1:0]       r_m_pres;

    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_fs_entry fs_rd;
    t_fs_wr    fs_wr;

    logic [XW-1:0]           f_ext;
    logic [IDX_W-1:0]        f_idx;
    logic                    in_range;
    logic                    allowed;
    logic                    consider;
    logic signed [POS_W-1:0] pu;
    logic signed [POS_W-1:0] pv;
    logic signed [POS_W-1:0] pn;
    logic [POS_W-1:0]        mag_u;
    logic [POS_W-1:0]        mag_v;
    logic [POS_W-1:0]        nrm_dist;
    logic [EXT_W-1:0]        ext_u;
    logic [EXT_W-1:0]        ext_v;
    logic                    touch_c;
    logic [EXT_W-1:0]        pres_x;
    logic [DIVIDEND_W-1:0]   pres_num;
    logic signed [16:0]      du;
    logic signed [16:0]      dv;
    logic                    moved;
    logic                    ev_valid;
    logic [KIND_W-1:0]       ev_kind;
    logic signed [UV_W-1:0]  ev_u;
    logic signed [UV_W-1:0]  ev_v;
    logic [PRES_W-1:0]       ev_pres;
    logic                    slot_free;
    logic                    emit_load;

    // signed quotient plus one half, saturated to q2.14
    function automatic logic signed [UV_W-1:0] f_to_uv(input logic [QUOT_W-1:0] q,
                                                       input logic neg);
        logic signed [19:0] mag;
        logic signed [19:0] s;
        mag = $signed({3'b000, q[QUOT_W-2:0]});
        s   = (neg ? -mag : mag) + HALF_Q14;
        if (q[QUOT_W-1]) begin
            f_to_uv = neg ? UV_MIN[UV_W-1:0] : UV_MAX[UV_W-1:0];
        end else if (s > UV_MAX) begin
            f_to_uv = UV_MAX[UV_W-1:0];
        end else if (s < UV_MIN) begin
            f_to_uv = UV_MIN[UV_W-1:0];
        end else begin
            f_to_uv = s[UV_W-1:0];
        end
    endfunction

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b0;
            r_normal_axis <= RST_NORMAL_AXIS;
            r_extent_u    <= RST_EXTENT;
            r_extent_v    <= RST_EXTENT;
            r_touch_dist  <= RST_TOUCH_DIST;
            r_allowed     <= RST_ALLOWED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLED:     r_enabled     <= i_cfg_data[0];
                CFG_NORMAL_AXIS: r_normal_axis <= i_cfg_data[1:0];
                CFG_EXTENT_U:    r_extent_u    <= i_cfg_data[EXT_W-1:0];
                CFG_EXTENT_V:    r_extent_v    <= i_cfg_data[EXT_W-1:0];
                CFG_TOUCH_DIST:  r_touch_dist  <= i_cfg_data[EXT_W-1:0];
                CFG_ALLOWED:     r_allowed     <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // ---- sample capture on input transfer ----
    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_finger <= s_axis_tdata[2:0];
            r_pos_x  <= s_axis_tdata[26:3];
            r_pos_y  <= s_axis_tdata[50:27];
            r_pos_z  <= s_axis_tdata[74:51];
        end
    end

    // finger filtering: out-of-range index dropped, mask covers fingers 0-4 only
    assign f_ext    = XW'(r_finger);
    assign f_idx    = f_ext[IDX_W-1:0];
    assign in_range = (f_ext < XW'(FINGER_COUNT));

    always_comb begin
        allowed = 1'b1;
        for (int i = 0; i < 5; i++) begin
            if (r_finger == FINGER_W'(i)) begin
                allowed = r_allowed[i];
            end
        end
    end

    assign consider = r_enabled && in_range && allowed;

    // ---- axis selection, code three behaves as z ----
    always_comb begin
        case (r_normal_axis)
            AXIS_X: begin
                pu = r_pos_y;
                pv = r_pos_z;
                pn = r_pos_x;
            end
            AXIS_Y: begin
                pu = r_pos_x;
                pv = r_pos_z;
                pn = r_pos_y;
            end
            default: begin
                pu = r_pos_x;
                pv = r_pos_y;
                pn = r_pos_z;
            end
        endcase
    end

    assign mag_u    = pu[POS_W-1] ? (~pu + 1'b1) : pu;
    assign mag_v    = pv[POS_W-1] ? (~pv + 1'b1) : pv;
    assign nrm_dist = pn[POS_W-1] ? (~pn + 1'b1) : pn;

    // zero extent counts as one
    assign ext_u = (r_extent_u == '0) ? EXT_W'(1) : r_extent_u;
    assign ext_v = (r_extent_v == '0) ? EXT_W'(1) : r_extent_v;

    // touch test on registered uv
    assign touch_c = !r_u[UV_W-1] && (r_u <= ONE_Q14) &&
                     !r_v[UV_W-1] && (r_v <= ONE_Q14) &&
                     ({1'b0, r_touch_dist} >= nrm_dist);

    // 65535 * (distance - d) as (x << 16) - x; zero threshold divides to all ones
    assign pres_x   = r_touch_dist - nrm_dist[EXT_W-1:0];
    assign pres_num = {pres_x, 16'h0000} - {16'h0000, pres_x};

    // ---- sequencer and divider requests ----
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.top      = TOP_UV;
        div_req.dividend = {1'b0, mag_u, 14'b0};
        div_req.divisor  = ext_u;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (consider) begin
                    div_req.start = 1'b1;
                    n_state       = S_DIVU;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIVU: begin
                div_req.dividend = {1'b0, mag_v, 14'b0};
                div_req.divisor  = ext_v;
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    n_state       = S_DIVV;
                end
            end
            S_DIVV: begin
                if (div_rsp.done) begin
                    n_state = S_TOUCH;
                end
            end
            S_TOUCH: begin
                div_req.top      = TOP_PRES;
                div_req.dividend = pres_num;
                div_req.divisor  = r_touch_dist;
                if (touch_c) begin
                    div_req.start = 1'b1;
                    n_state       = S_PRES;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_PRES: begin
                if (div_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!ev_valid || slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIVU && div_rsp.done) begin
            r_u <= f_to_uv(div_rsp.quot, pu[POS_W-1]);
        end
        if (r_state == S_DIVV && div_rsp.done) begin
            r_v <= f_to_uv(div_rsp.quot, pv[POS_W-1]);
        end
        if (r_state == S_TOUCH) begin
            r_touch <= touch_c;
        end
        if (r_state == S_PRES && div_rsp.done) begin
            r_pres <= div_rsp.quot[PRES_W-1:0];
        end
    end

    ptet_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---- event decision ----
    assign du    = 17'(r_u) - 17'(fs_rd.last_u);
    assign dv    = 17'(r_v) - 17'(fs_rd.last_v);
    assign moved = (du > MOVE_TOL) || (du < -MOVE_TOL) ||
                   (dv > MOVE_TOL) || (dv < -MOVE_TOL);

    always_comb begin
        ev_valid             = 1'b0;
        ev_kind              = EV_BEGAN;
        ev_u                 = r_u;
        ev_v                 = r_v;
        ev_pres              = r_pres;
        fs_wr.entry.touching = 1'b1;
        fs_wr.entry.last_u   = r_u;
        fs_wr.entry.last_v   = r_v;
        if (r_touch && !fs_rd.touching) begin
            ev_valid = 1'b1;
        end else if (r_touch) begin
            ev_valid = moved;
            ev_kind  = EV_MOVED;
        end else if (fs_rd.touching) begin
            // release reports the stored uv and clears it
            ev_valid             = 1'b1;
            ev_kind              = EV_ENDED;
            ev_u                 = fs_rd.last_u;
            ev_v                 = fs_rd.last_v;
            ev_pres              = '0;
            fs_wr.entry.touching = 1'b0;
            fs_wr.entry.last_u   = MINUS_ONE_Q14;
            fs_wr.entry.last_v   = MINUS_ONE_Q14;
        end
        fs_wr.we = (r_state == S_EMIT) && ev_valid && slot_free;
    end

    assign slot_free = !r_m_valid || m_axis_tready;
    assign emit_load = (r_state == S_EMIT) && ev_valid && slot_free;

    ptet_fstate #(
        .FINGER_COUNT (FINGER_COUNT),
        .IDX_W        (IDX_W)
    ) u_fstate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (f_idx),
        .i_wr    (fs_wr),
        .o_rd    (fs_rd)
    );

    // ---- output register, next sample may start while an event waits ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_m_kind   <= ev_kind;
            r_m_finger <= r_finger;
            r_m_u      <= ev_u;
            r_m_v      <= ev_v;
            r_m_pres   <= ev_pres;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tdata  = {5'b00000, r_m_pres, r_m_v, r_m_u, r_m_finger};

`ifndef NO_ASSERTIONS
    // a sample transfer always starts a busy period
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after a sample transfer");

    // divider only finishes while the sequencer waits on it
    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIVU || r_state == S_DIVV || r_state == S_PRES))
        else $error("divider finished outside a divide step");

    // release events carry zero pressure
    a_ended_zero_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == EV_ENDED) |-> (m_axis_tdata[50:35] == '0))
        else $error("ended event with nonzero pressure");

    // an event is only loaded while the output slot can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
        else $error("pending event overwritten");
`endif

endmodule
